// File: rtl/core/dwss_pkg.sv
// Shared constants and types for the daily/weekly sample statistics block.
package dwss_pkg;

  // Sample and result field widths
  localparam int unsigned SampleW        = 16;
  localparam int unsigned DayIdxW        = 3;
  localparam int unsigned HourIdxW       = 5;
  localparam int unsigned HotW           = 3;

  // Parameter defaults
  localparam int unsigned HoursPerDayDef = 24;
  localparam int unsigned DaysPerWeekDef = 7;

  // Hot threshold after reset: 30 degrees in 1/128 degree units
  localparam logic signed [SampleW-1:0] HotThresholdRst = 16'sd3840;

  // Hot day count saturates here
  localparam logic [HotW-1:0] HotMax = 3'd7;

  typedef enum logic {
    KIND_DAY  = 1'b0,
    KIND_WEEK = 1'b1
  } kind_e;

  typedef logic signed [SampleW-1:0] sample_t;

  // Daily figures captured at the last hour of a day
  typedef struct packed {
    logic [DayIdxW-1:0] day_index;
    logic               week_end;
    sample_t            max_v;
    sample_t            min_v;
  } day_stat_t;

  // Weekly figures captured at the last hour of a week
  typedef struct packed {
    sample_t             max_v;
    sample_t             min_v;
    logic [HotW-1:0]     hot_days;
    logic [DayIdxW-1:0]  peak_day;
    logic [HourIdxW-1:0] peak_hour;
  } week_stat_t;

  // One result item as it leaves the block
  typedef struct packed {
    kind_e               kind;
    logic [DayIdxW-1:0]  day_index;
    sample_t             max_v;
    sample_t             min_v;
    sample_t             mean_v;
    logic [HotW-1:0]     hot_days;
    logic [DayIdxW-1:0]  peak_day;
    logic [HourIdxW-1:0] peak_hour;
    logic                last;
  } result_t;

endpackage

// File: rtl/core/dwss_accum.sv
// Running day and week accumulators: max, min, sum, peak position, hot day count.
module dwss_accum import dwss_pkg::*; #(
  parameter int unsigned HOURS_PER_DAY = HoursPerDayDef,
  parameter int unsigned DAYS_PER_WEEK = DaysPerWeekDef,
  localparam int unsigned DaySumW  = SampleW + $clog2(HOURS_PER_DAY),
  localparam int unsigned WeekSumW = SampleW + $clog2(HOURS_PER_DAY * DAYS_PER_WEEK)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  sample_t                    sample_i,
  input  sample_t                    hot_threshold_i,
  output logic                       close_o,
  output day_stat_t                  day_o,
  output week_stat_t                 week_o,
  output logic signed [DaySumW-1:0]  day_sum_o,
  output logic signed [WeekSumW-1:0] week_sum_o
);

  localparam int unsigned HourW   = $clog2(HOURS_PER_DAY);
  localparam int unsigned DayCntW = (DAYS_PER_WEEK > 1) ? $clog2(DAYS_PER_WEEK) : 1;
  localparam logic [HourW-1:0]   LastHour = HourW'(HOURS_PER_DAY - 1);
  localparam logic [DayCntW-1:0] LastDay  = DayCntW'(DAYS_PER_WEEK - 1);
  localparam logic signed [DaySumW:0] HoursMul = (DaySumW+1)'(HOURS_PER_DAY);

  logic [HourW-1:0]           hour_q, hour_d;
  logic [DayCntW-1:0]         day_q, day_d;
  sample_t                    day_max_q, day_max_d;
  sample_t                    day_min_q, day_min_d;
  logic signed [DaySumW-1:0]  day_sum_q, day_sum_d;
  sample_t                    week_max_q, week_max_d;
  sample_t                    week_min_q, week_min_d;
  logic signed [WeekSumW-1:0] week_sum_q, week_sum_d;
  logic [DayCntW-1:0]         best_day_q, best_day_d;
  logic [HourW-1:0]           best_hour_q, best_hour_d;
  logic [HotW-1:0]            hot_q, hot_d;

  logic                       first_hour;
  logic                       first_week;
  logic                       close;
  logic                       week_end;
  logic signed [DaySumW-1:0]  sx_day;
  logic signed [WeekSumW-1:0] sx_week;
  logic signed [DaySumW:0]    hot_limit;
  logic                       is_hot;
  logic [HotW-1:0]            hot_base;

  // Fold the sample into the day and week figures
  always_comb begin
    first_hour = (hour_q == '0);
    first_week = first_hour && (day_q == '0);
    close      = (hour_q == LastHour);
    week_end   = (day_q == LastDay);
    sx_day     = DaySumW'(sample_i);
    sx_week    = WeekSumW'(sample_i);

    if (first_hour) begin
      day_max_d = sample_i;
      day_min_d = sample_i;
      day_sum_d = sx_day;
    end else begin
      day_max_d = (sample_i > day_max_q) ? sample_i : day_max_q;
      day_min_d = (sample_i < day_min_q) ? sample_i : day_min_q;
      day_sum_d = day_sum_q + sx_day;
    end

    if (first_week) begin
      week_max_d  = sample_i;
      week_min_d  = sample_i;
      week_sum_d  = sx_week;
      best_day_d  = '0;
      best_hour_d = '0;
      hot_base    = '0;
    end else begin
      week_max_d  = week_max_q;
      best_day_d  = best_day_q;
      best_hour_d = best_hour_q;
      // Only a strictly larger sample moves the peak
      if (sample_i > week_max_q) begin
        week_max_d  = sample_i;
        best_day_d  = day_q;
        best_hour_d = hour_q;
      end
      week_min_d = (sample_i < week_min_q) ? sample_i : week_min_q;
      week_sum_d = week_sum_q + sx_week;
      hot_base   = hot_q;
    end

    // Hot test on the exact mean: sum above threshold times hours
    hot_limit = (DaySumW+1)'(hot_threshold_i) * HoursMul;
    is_hot    = ((DaySumW+1)'(day_sum_d) > hot_limit);
    hot_d     = (close && is_hot && (hot_base != HotMax)) ? hot_base + HotW'(1) : hot_base;

    // Advance the hour and day counters
    hour_d = close ? '0 : hour_q + HourW'(1);
    day_d  = day_q;
    if (close) begin
      day_d = week_end ? '0 : day_q + DayCntW'(1);
    end
  end

  // Hold the state between samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q      <= '0;
      day_q       <= '0;
      day_max_q   <= '0;
      day_min_q   <= '0;
      day_sum_q   <= '0;
      week_max_q  <= '0;
      week_min_q  <= '0;
      week_sum_q  <= '0;
      best_day_q  <= '0;
      best_hour_q <= '0;
      hot_q       <= '0;
    end else if (step_i) begin
      hour_q      <= hour_d;
      day_q       <= day_d;
      day_max_q   <= day_max_d;
      day_min_q   <= day_min_d;
      day_sum_q   <= day_sum_d;
      week_max_q  <= week_max_d;
      week_min_q  <= week_min_d;
      week_sum_q  <= week_sum_d;
      best_day_q  <= best_day_d;
      best_hour_q <= best_hour_d;
      hot_q       <= hot_d;
    end
  end

  // Figures that close the day and the week
  always_comb begin
    close_o            = close;
    day_o.day_index    = DayIdxW'(day_q);
    day_o.week_end     = week_end;
    day_o.max_v        = day_max_d;
    day_o.min_v        = day_min_d;
    week_o.max_v       = week_max_d;
    week_o.min_v       = week_min_d;
    week_o.hot_days    = hot_d;
    week_o.peak_day    = DayIdxW'(best_day_d);
    week_o.peak_hour   = HourIdxW'(best_hour_d);
    day_sum_o          = day_sum_d;
    week_sum_o         = week_sum_d;
  end

endmodule

// File: rtl/core/dwss_div.sv
// Signed divide by a fixed count, truncated toward zero, by reciprocal multiply.
module dwss_div import dwss_pkg::*; #(
  parameter int unsigned SUM_W   = SampleW + 5,
  parameter int unsigned DIVISOR = HoursPerDayDef
) (
  input  logic signed [SUM_W-1:0] sum_i,
  output sample_t                 mean_o
);

  // Reciprocal rounded up, wide enough to be exact for every SUM_W-bit magnitude
  localparam int unsigned Shift  = SUM_W + $clog2(DIVISOR);
  localparam int unsigned RecipW = SUM_W + 2;
  localparam int unsigned ProdW  = SUM_W + RecipW;
  localparam logic [63:0] RecipFull =
    ((64'd1 << Shift) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RecipW-1:0] Recip = RecipFull[RecipW-1:0];

  logic               neg;
  logic [SUM_W-1:0]   mag;
  logic [ProdW-1:0]   prod;
  logic [SampleW:0]   quo;

  // Divide the magnitude, then restore the sign
  always_comb begin
    neg    = sum_i[SUM_W-1];
    mag    = neg ? SUM_W'(-sum_i) : SUM_W'(sum_i);
    prod   = ProdW'(mag) * ProdW'(Recip);
    quo    = (SampleW+1)'(prod >> Shift);
    mean_o = neg ? SampleW'(-quo) : SampleW'(quo);
  end

endmodule

// File: rtl/core/dwss_out.sv
// Result register: presents the daily result, then the weekly one when the week ends.
module dwss_out import dwss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  day_stat_t  day_i,
  input  week_stat_t week_i,
  input  sample_t    day_mean_i,
  input  sample_t    week_mean_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output result_t    res_o
);

  logic    valid_q, valid_d;
  logic    show_week_q, show_week_d;
  logic    week_pend_q, week_pend_d;
  result_t day_res_q, day_res_d;
  result_t week_res_q, week_res_d;
  logic    xfer;
  logic    more;
  logic    load;

  // Build both result items from the captured figures
  always_comb begin
    day_res_d.kind       = KIND_DAY;
    day_res_d.day_index  = day_i.day_index;
    day_res_d.max_v      = day_i.max_v;
    day_res_d.min_v      = day_i.min_v;
    day_res_d.mean_v     = day_mean_i;
    day_res_d.hot_days   = '0;
    day_res_d.peak_day   = '0;
    day_res_d.peak_hour  = '0;
    day_res_d.last       = !day_i.week_end;

    week_res_d.kind      = KIND_WEEK;
    week_res_d.day_index = '0;
    week_res_d.max_v     = week_i.max_v;
    week_res_d.min_v     = week_i.min_v;
    week_res_d.mean_v    = week_mean_i;
    week_res_d.hot_days  = week_i.hot_days;
    week_res_d.peak_day  = week_i.peak_day;
    week_res_d.peak_hour = week_i.peak_hour;
    week_res_d.last      = 1'b1;
  end

  // Accept a new pair once the current one is fully sent
  always_comb begin
    xfer       = valid_q && !out_stall_i;
    more       = valid_q && !show_week_q && week_pend_q;
    in_ready_o = !valid_q || (xfer && !more);
    load       = in_ready_o && in_valid_i;

    valid_d     = valid_q;
    show_week_d = show_week_q;
    week_pend_d = week_pend_q;
    if (load) begin
      valid_d     = 1'b1;
      show_week_d = 1'b0;
      week_pend_d = day_i.week_end;
    end else if (xfer) begin
      if (more) begin
        show_week_d = 1'b1;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      show_week_q <= 1'b0;
      week_pend_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      show_week_q <= show_week_d;
      week_pend_q <= week_pend_d;
    end
  end

  // Hold the payload until the next load
  always_ff @(posedge clk_i) begin
    if (load) begin
      day_res_q  <= day_res_d;
      week_res_q <= week_res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = show_week_q ? week_res_q : day_res_q;

endmodule

// File: rtl/core/daily_weekly_sample_stats_top.sv
// Top level of the daily/weekly sample statistics block.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   sample_i
//  out      output     out_valid_o / out_stall_i kind_o .. last_o (nine fields)
//  cfg      input      cfg_we_i                  cfg_data_i (hot threshold)
//
// One sample is taken every cycle while in_stall_o is low. A sample closing a day shows its
// daily result after passing the input, summary and result registers; at a week's last hour
// the weekly result follows once the daily one is taken, so that result register holds both.
// Reset loads the hot threshold with 30 degrees and clears all counters; no clearing pass.
// A held out_stall_i freezes the result register and then backs up through the
// summary register and the input register to in_stall_o.
module daily_weekly_sample_stats_top import dwss_pkg::*; #(
  parameter int unsigned HOURS_PER_DAY = HoursPerDayDef,
  parameter int unsigned DAYS_PER_WEEK = DaysPerWeekDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  sample_t             cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sample_t             sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                kind_o,
  output logic [DayIdxW-1:0]  day_index_o,
  output sample_t             max_value_o,
  output sample_t             min_value_o,
  output sample_t             mean_value_o,
  output logic [HotW-1:0]     hot_days_o,
  output logic [DayIdxW-1:0]  peak_day_o,
  output logic [HourIdxW-1:0] peak_hour_o,
  output logic                last_o
);

  localparam int unsigned DaySumW  = SampleW + $clog2(HOURS_PER_DAY);
  localparam int unsigned WeekSumW = SampleW + $clog2(HOURS_PER_DAY * DAYS_PER_WEEK);

  sample_t                    hot_threshold_q;
  logic                       in_valid_q;
  sample_t                    sample_q;
  logic                       close;
  logic                       s1_adv;
  logic                       step;
  day_stat_t                  day_stat;
  week_stat_t                 week_stat;
  logic signed [DaySumW-1:0]  day_sum;
  logic signed [WeekSumW-1:0] week_sum;
  logic                       s2_valid_q;
  logic                       s2_ready;
  day_stat_t                  day_stat_q;
  week_stat_t                 week_stat_q;
  logic signed [DaySumW-1:0]  day_sum_q;
  logic signed [WeekSumW-1:0] week_sum_q;
  sample_t                    day_mean;
  sample_t                    week_mean;
  logic                       out_ready;
  result_t                    res;

  // Hot threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hot_threshold_q <= HotThresholdRst;
    end else if (cfg_we_i) begin
      hot_threshold_q <= cfg_data_i;
    end
  end

  // Input register: only a day-closing sample needs room downstream
  assign s1_adv     = !close || s2_ready;
  assign step       = in_valid_q && s1_adv;
  assign in_stall_o = in_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      sample_q <= sample_i;
    end
  end

  dwss_accum #(
    .HOURS_PER_DAY (HOURS_PER_DAY),
    .DAYS_PER_WEEK (DAYS_PER_WEEK)
  ) u_accum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .sample_i        (sample_q),
    .hot_threshold_i (hot_threshold_q),
    .close_o         (close),
    .day_o           (day_stat),
    .week_o          (week_stat),
    .day_sum_o       (day_sum),
    .week_sum_o      (week_sum)
  );

  // Summary register: capture the closing figures of a day
  assign s2_ready = !s2_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= step && close;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && step && close) begin
      day_stat_q  <= day_stat;
      week_stat_q <= week_stat;
      day_sum_q   <= day_sum;
      week_sum_q  <= week_sum;
    end
  end

  // Means of the day and of the week
  dwss_div #(
    .SUM_W   (DaySumW),
    .DIVISOR (HOURS_PER_DAY)
  ) u_day_div (
    .sum_i  (day_sum_q),
    .mean_o (day_mean)
  );

  dwss_div #(
    .SUM_W   (WeekSumW),
    .DIVISOR (HOURS_PER_DAY * DAYS_PER_WEEK)
  ) u_week_div (
    .sum_i  (week_sum_q),
    .mean_o (week_mean)
  );

  dwss_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid_q),
    .in_ready_o  (out_ready),
    .day_i       (day_stat_q),
    .week_i      (week_stat_q),
    .day_mean_i  (day_mean),
    .week_mean_i (week_mean),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  // Unpack the result onto the output fields
  assign kind_o       = res.kind;
  assign day_index_o  = res.day_index;
  assign max_value_o  = res.max_v;
  assign min_value_o  = res.min_v;
  assign mean_value_o = res.mean_v;
  assign hot_days_o   = res.hot_days;
  assign peak_day_o   = res.peak_day;
  assign peak_hour_o  = res.peak_hour;
  assign last_o       = res.last;

  // An empty input register never stalls the input
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

  // A weekly result always carries last
  a_week_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> last_o)
    else $error("weekly result without last");

  // The weekly result directly follows the week's final daily result
  a_week_follows_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !kind_o && !last_o |=> out_valid_o && kind_o)
    else $error("week's final daily result not followed by weekly result");

  // A daily result that is last is never followed by a weekly one
  a_no_stray_week: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !kind_o && last_o |=> !(out_valid_o && kind_o))
    else $error("weekly result after a mid-week daily result");

endmodule
